@@ rtl/char_lcd_text_writer_defines.svh @@
// Assertion macros used by the nibble sender of the character display writer RTL.
`ifndef CHAR_LCD_TEXT_WRITER_DEFINES_SVH
`define CHAR_LCD_TEXT_WRITER_DEFINES_SVH
`ifndef SYNTH
// Condition holds at every clock edge out of reset.
`define CLW_ASSERT(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("clw check failed");
// Antecedent implies consequent in the same cycle.
`define CLW_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("clw implication failed");
// Antecedent implies consequent in the next cycle.
`define CLW_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("clw next-cycle check failed");
`else
`define CLW_ASSERT(lbl, expr)
`define CLW_ASSERT_IMPL(lbl, ante, cons)
`define CLW_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ rtl/clw_pkg.sv @@
// Types, command codes and helper functions for the character display writer.
`default_nettype none
package clw_pkg;

	// Operation codes carried in the func field.
	typedef enum logic [2:0] {
		FUNC_CHAR      = 3'd0,
		FUNC_CURSOR    = 3'd1,
		FUNC_RAW_CMD   = 3'd2,
		FUNC_RAW_DATA  = 3'd3,
		FUNC_DISP_CTRL = 3'd4,
		FUNC_INIT      = 3'd5
	} clw_func_t;

	// Configuration register indexes.
	localparam logic [1:0] CFG_ROW_COUNT    = 2'd0;
	localparam logic [1:0] CFG_COLUMN_COUNT = 2'd1;
	localparam logic [1:0] CFG_WRAP_ENABLE  = 2'd2;

	// Standard controller command codes.
	localparam logic [7:0] CMD_CLEAR      = 8'h01;
	localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
	localparam logic [7:0] CMD_DISP_CTRL  = 8'h08;
	localparam logic [7:0] CMD_FUNC_SET   = 8'h20;
	localparam logic [7:0] FUNC_SET_2LINE = 8'h08;
	localparam logic [7:0] CMD_SET_DDRAM  = 8'h80;

	// Init wake-up nibbles and display bits after init (display on).
	localparam logic [3:0] INIT_WAKE      = 4'h3;
	localparam logic [3:0] INIT_4BIT      = 4'h2;
	localparam logic [3:0] INIT_4BIT_STEP = 4'd3;
	localparam logic [3:0] INIT_LAST_STEP = 4'd11;
	localparam logic [2:0] INIT_DISP_BITS = 3'b100;

	// Special characters.
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0] CHAR_RETURN  = 8'h0D;

	// Register select values.
	localparam logic RS_CMD  = 1'b0;
	localparam logic RS_DATA = 1'b1;

	// DDRAM start address of each row.
	localparam logic [6:0] ROW_BASE [4] = '{7'h00, 7'h40, 7'h14, 7'h54};

	// One queued job: an optional cursor command ahead of a main byte, or init.
	typedef struct packed {
		logic       is_init;
		logic       has_pre;
		logic [7:0] pre_byte;
		logic [7:0] main_byte;
		logic       main_rs;
	} clw_cmd_t;

	// Rows at or past the row count, or past the last offset, fold to row 0.
	function automatic logic [1:0] row_fold(logic [2:0] row, logic [2:0] rows);
		logic [1:0] res;
		if (row >= rows || row[2]) begin
			res = 2'd0;
		end else begin
			res = row[1:0];
		end
		return res;
	endfunction

	// Set-DDRAM-address command for a row and column.
	function automatic logic [7:0] ddram_cmd(logic [1:0] row, logic [7:0] col);
		logic [7:0] sum;
		sum = col + {1'b0, ROW_BASE[row]};
		return CMD_SET_DDRAM | {1'b0, sum[6:0]};
	endfunction

	// Nibble sent at each step of the init sequence.
	function automatic logic [3:0] init_nibble(logic [3:0] step, logic [7:0] fset);
		logic [7:0] b;
		case (step[3:1])
			3'd2: b = fset;
			3'd3: b = CMD_DISP_CTRL | {5'd0, INIT_DISP_BITS};
			3'd4: b = CMD_CLEAR;
			3'd5: b = CMD_ENTRY_MODE;
			default: b = 8'h00;
		endcase
		if (step[3:2] == 2'd0) begin
			return (step == INIT_4BIT_STEP) ? INIT_4BIT : INIT_WAKE;
		end
		return step[0] ? b[3:0] : b[7:4];
	endfunction

endpackage
`default_nettype wire

@@ rtl/clw_if.sv @@
// Channel interfaces: operation items in, display nibbles out.
`default_nettype none

interface clw_item_if;
	logic       valid;
	logic       ready;
	logic [2:0] func;
	logic [7:0] byte_value;
	logic [2:0] target_row;
	logic [5:0] target_col;
	logic [2:0] ctrl_mask;
	logic       ctrl_set;

	modport source (output valid, func, byte_value, target_row, target_col,
		ctrl_mask, ctrl_set, input ready);
	modport sink (input valid, func, byte_value, target_row, target_col,
		ctrl_mask, ctrl_set, output ready);
endinterface

interface clw_nib_if;
	logic       valid;
	logic       ready;
	logic [3:0] nibble;
	logic       reg_select;
	logic       last;

	modport source (output valid, nibble, reg_select, last, input ready);
	modport sink (input valid, nibble, reg_select, last, output ready);
endinterface

`default_nettype wire

@@ rtl/char_lcd_text_writer.sv @@
// Top level of the character display writer, 4-bit nibble output.
//
//   channel  dir  payload                                           beat
//   item     in   func, byte_value, target_row, target_col, mask    one operation
//   lcd      out  nibble, reg_select, last                          one enable pulse
//   cfg      in   cfg_wen, cfg_idx, cfg_data                        register write
//
// The nibble sender emits one beat per cycle while lcd is ready; a character takes two
// nibbles, four when auto-wrap adds a cursor command, and init takes twelve, all set by the sender.
// The front end takes an item per cycle while the job queue has room.
// arst_n clears cursor, control bits, queue and output; registers go to defaults.
// A stalled lcd output holds its beat; new items still fill the queue meanwhile.
`default_nettype none
module char_lcd_text_writer import clw_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_wen,
	input  wire logic [1:0] cfg_idx,
	input  wire logic [5:0] cfg_data,
	clw_item_if.sink        item,
	clw_nib_if.source       lcd
);

	logic     push;
	logic     push_ready;
	clw_cmd_t push_cmd;
	logic     head_valid;
	logic     pop;
	clw_cmd_t head_cmd;

	clw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data),
		.item       (item),
		.push       (push),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	clw_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.head_valid (head_valid),
		.pop        (pop),
		.head_cmd   (head_cmd)
	);

	clw_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.lcd        (lcd)
	);

endmodule
`default_nettype wire

@@ rtl/clw_front.sv @@
// Front end: takes operations, tracks cursor and control bits, builds jobs.
`default_nettype none
module clw_front import clw_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_wen,
	input  wire logic [1:0] cfg_idx,
	input  wire logic [5:0] cfg_data,
	clw_item_if.sink        item,
	output logic            push,
	input  wire logic       push_ready,
	output clw_cmd_t        push_cmd
);

	logic [2:0] row_count_q;
	logic [5:0] column_count_q;
	logic       wrap_enable_q;
	logic [7:0] cursor_col_q;
	logic [1:0] cursor_row_q;
	logic [2:0] disp_bits_q;

	logic       accept;
	logic       known;
	logic       wrap;
	logic [1:0] wrap_row;
	logic [1:0] row_a;
	logic [7:0] col_a;
	logic [1:0] nl_row;
	logic [1:0] cr_row;
	logic [1:0] tgt_row;
	logic [2:0] ctrl_bits;
	logic [1:0] next_row;
	logic [7:0] next_col;
	logic [2:0] next_bits;
	clw_cmd_t   cmd;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q    <= 3'd2;
			column_count_q <= 6'd16;
			wrap_enable_q  <= 1'b0;
		end else if (cfg_wen) begin
			case (cfg_idx)
				CFG_ROW_COUNT:    row_count_q    <= cfg_data[2:0];
				CFG_COLUMN_COUNT: column_count_q <= cfg_data;
				CFG_WRAP_ENABLE:  wrap_enable_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Cursor movement candidates for the current item.
	always_comb begin
		wrap      = wrap_enable_q && (cursor_col_q >= {2'b00, column_count_q});
		wrap_row  = row_fold({1'b0, cursor_row_q} + 3'd1, row_count_q);
		row_a     = wrap ? wrap_row : cursor_row_q;
		col_a     = wrap ? 8'd0 : cursor_col_q;
		nl_row    = row_fold({1'b0, row_a} + 3'd1, row_count_q);
		cr_row    = row_fold({1'b0, row_a}, row_count_q);
		tgt_row   = row_fold(item.target_row, row_count_q);
		ctrl_bits = item.ctrl_set ? (disp_bits_q | item.ctrl_mask)
			: (disp_bits_q & ~item.ctrl_mask);
	end

	// Job and next state by operation.
	always_comb begin
		cmd       = '0;
		known     = 1'b1;
		next_row  = cursor_row_q;
		next_col  = cursor_col_q;
		next_bits = disp_bits_q;
		case (clw_func_t'(item.func))
			FUNC_CHAR: begin
				cmd.has_pre  = wrap;
				cmd.pre_byte = ddram_cmd(wrap_row, 8'd0);
				if (item.byte_value == CHAR_NEWLINE) begin
					next_row      = nl_row;
					next_col      = col_a;
					cmd.main_byte = ddram_cmd(nl_row, col_a);
					cmd.main_rs   = RS_CMD;
				end else if (item.byte_value == CHAR_RETURN) begin
					next_row      = cr_row;
					next_col      = 8'd0;
					cmd.main_byte = ddram_cmd(cr_row, 8'd0);
					cmd.main_rs   = RS_CMD;
				end else begin
					next_row      = row_a;
					next_col      = col_a + 8'd1;
					cmd.main_byte = item.byte_value;
					cmd.main_rs   = RS_DATA;
				end
			end
			FUNC_CURSOR: begin
				next_row      = tgt_row;
				next_col      = {2'b00, item.target_col};
				cmd.main_byte = ddram_cmd(tgt_row, {2'b00, item.target_col});
				cmd.main_rs   = RS_CMD;
			end
			FUNC_RAW_CMD: begin
				cmd.main_byte = item.byte_value;
				cmd.main_rs   = RS_CMD;
			end
			FUNC_RAW_DATA: begin
				cmd.main_byte = item.byte_value;
				cmd.main_rs   = RS_DATA;
			end
			FUNC_DISP_CTRL: begin
				next_bits     = ctrl_bits;
				cmd.main_byte = CMD_DISP_CTRL | {5'd0, ctrl_bits};
				cmd.main_rs   = RS_CMD;
			end
			FUNC_INIT: begin
				next_row      = 2'd0;
				next_col      = 8'd0;
				next_bits     = INIT_DISP_BITS;
				cmd.is_init   = 1'b1;
				cmd.main_byte = (row_count_q > 3'd1) ? (CMD_FUNC_SET | FUNC_SET_2LINE)
					: CMD_FUNC_SET;
				cmd.main_rs   = RS_CMD;
			end
			default: known = 1'b0;
		endcase
	end

	assign item.ready = push_ready;
	assign accept     = item.valid && push_ready;
	assign push       = accept && known;
	assign push_cmd   = cmd;

	// Cursor and control state follow each accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_col_q <= 8'd0;
			cursor_row_q <= 2'd0;
			disp_bits_q  <= 3'd0;
		end else if (accept) begin
			cursor_col_q <= next_col;
			cursor_row_q <= next_row;
			disp_bits_q  <= next_bits;
		end
	end

endmodule
`default_nettype wire

@@ rtl/clw_queue.sv @@
// Small job queue between the front end and the nibble sender.
`default_nettype none
module clw_queue import clw_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	output logic          push_ready,
	input  wire clw_cmd_t push_cmd,
	output logic          head_valid,
	input  wire logic     pop,
	output clw_cmd_t      head_cmd
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	clw_cmd_t      mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign push_ready = (count_q != FULL_CNT);
	assign head_valid = (count_q != '0);
	assign head_cmd   = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/clw_back.sv @@
// Nibble sender: walks each queued job and drives the registered output.
`default_nettype none
`include "char_lcd_text_writer_defines.svh"
module clw_back import clw_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     head_valid,
	input  wire clw_cmd_t head_cmd,
	output logic          pop,
	clw_nib_if.source     lcd
);

	logic [3:0] step_q;
	logic       vld_q;
	logic [3:0] nib_q;
	logic       rs_q;
	logic       last_q;

	logic       adv;
	logic       use_pre;
	logic [7:0] cur_byte;
	logic [3:0] nib;
	logic       rs;
	logic       last;

	// Nibble for the current step of the head job.
	always_comb begin
		use_pre  = head_cmd.has_pre && !step_q[1];
		cur_byte = use_pre ? head_cmd.pre_byte : head_cmd.main_byte;
		if (head_cmd.is_init) begin
			nib  = init_nibble(step_q, head_cmd.main_byte);
			rs   = RS_CMD;
			last = (step_q == INIT_LAST_STEP);
		end else begin
			nib  = step_q[0] ? cur_byte[3:0] : cur_byte[7:4];
			rs   = use_pre ? RS_CMD : head_cmd.main_rs;
			last = head_cmd.has_pre ? (step_q == 4'd3) : (step_q == 4'd1);
		end
	end

	assign adv = !vld_q || lcd.ready;
	assign pop = adv && head_valid && last;

	// Step counter and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= 4'd0;
			vld_q  <= 1'b0;
		end else if (adv) begin
			vld_q <= head_valid;
			if (head_valid) begin
				step_q <= last ? 4'd0 : step_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && head_valid) begin
			nib_q  <= nib;
			rs_q   <= rs;
			last_q <= last;
		end
	end

	assign lcd.valid      = vld_q;
	assign lcd.nibble     = nib_q;
	assign lcd.reg_select = rs_q;
	assign lcd.last       = last_q;

	// A job in progress never leaves the queue early.
	`CLW_ASSERT_IMPL(a_mid_job_head, step_q != 4'd0, head_valid)
	// The step counter stays within the longest job.
	`CLW_ASSERT(a_step_range, step_q <= INIT_LAST_STEP)
	// Byte jobs never go past four nibbles.
	`CLW_ASSERT_IMPL(a_byte_job_len, head_valid && !head_cmd.is_init, step_q <= 4'd3)
	// Retiring a job puts its final nibble on the output.
	`CLW_ASSERT_NEXT(a_pop_last, pop, vld_q && last_q)

endmodule
`default_nettype wire
